// ===== sv/msl_pkg.sv =====
// Shared types, constants and arithmetic helpers of the multi-stream LCG.
package msl_pkg;

  localparam int unsigned StreamCount  = 101;
  localparam int unsigned DefaultCount = 101;
  localparam int unsigned StreamW      = 7;
  localparam int unsigned AddrW        = (StreamCount > 1) ? $clog2(StreamCount) : 1;
  localparam int unsigned SeedW        = 31;
  localparam int unsigned FracW        = 24;
  localparam int unsigned MultW        = 15;
  localparam int unsigned ProdW        = SeedW + MultW;

  localparam logic [SeedW:0]   PrimeMod   = 32'h7FFF_FFFF;
  localparam logic [MultW-1:0] FirstMult  = 15'd24112;
  localparam logic [MultW-1:0] SecondMult = 15'd26143;

  typedef enum logic [1:0] {
    ACT_DRAW = 2'd0,
    ACT_SET  = 2'd1,
    ACT_READ = 2'd2
  } action_e;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [SeedW-1:0] wr_data;
  } ram_req_t;

  typedef struct packed {
    logic en;
    logic second;
  } mul_ctrl_t;

  localparam logic [SeedW-1:0] DefaultSeeds [DefaultCount] = '{
    31'd1,
    31'd1973272912, 31'd281629770,  31'd20006270,   31'd1280689831, 31'd2096730329,
    31'd1933576050, 31'd913566091,  31'd246780520,  31'd1363774876, 31'd604901985,
    31'd1511192140, 31'd1259851944, 31'd824064364,  31'd150493284,  31'd242708531,
    31'd75253171,   31'd1964472944, 31'd1202299975, 31'd233217322,  31'd1911216000,
    31'd726370533,  31'd403498145,  31'd993232223,  31'd1103205531, 31'd762430696,
    31'd1922803170, 31'd1385516923, 31'd76271663,   31'd413682397,  31'd726466604,
    31'd336157058,  31'd1432650381, 31'd1120463904, 31'd595778810,  31'd877722890,
    31'd1046574445, 31'd68911991,   31'd2088367019, 31'd748545416,  31'd622401386,
    31'd2122378830, 31'd640690903,  31'd1774806513, 31'd2132545692, 31'd2079249579,
    31'd78130110,   31'd852776735,  31'd1187867272, 31'd1351423507, 31'd1645973084,
    31'd1997049139, 31'd922510944,  31'd2045512870, 31'd898585771,  31'd243649545,
    31'd1004818771, 31'd773686062,  31'd403188473,  31'd372279877,  31'd1901633463,
    31'd498067494,  31'd2087759558, 31'd493157915,  31'd597104727,  31'd1530940798,
    31'd1814496276, 31'd536444882,  31'd1663153658, 31'd855503735,  31'd67784357,
    31'd1432404475, 31'd619691088,  31'd119025595,  31'd880802310,  31'd176192644,
    31'd1116780070, 31'd277854671,  31'd1366580350, 31'd1142483975, 31'd2026948561,
    31'd1053920743, 31'd786262391,  31'd1792203830, 31'd1494667770, 31'd1923011392,
    31'd1433700034, 31'd1244184613, 31'd1147297105, 31'd539712780,  31'd1545929719,
    31'd190641742,  31'd1645390429, 31'd264907697,  31'd620389253,  31'd1502074852,
    31'd927711160,  31'd364849192,  31'd2049576050, 31'd638580085,  31'd547070247
  };

  // Power-on seed of a stream.
  function automatic logic [SeedW-1:0] default_seed(input logic [StreamW-1:0] idx);
    logic [SeedW-1:0] seed;
    seed = 31'd1;
    if (32'(idx) < DefaultCount) begin
      seed = DefaultSeeds[idx];
    end
    return seed;
  endfunction

  // Fold a product of a 31-bit seed and a 15-bit multiplier modulo 2^31-1.
  function automatic logic [SeedW-1:0] fold_mod(input logic [ProdW-1:0] prod);
    logic [SeedW:0] sum;
    sum = {1'b0, prod[SeedW-1:0]} + (SeedW+1)'(prod[ProdW-1:SeedW]);
    if (sum >= PrimeMod) begin
      sum = sum - PrimeMod;
    end
    return sum[SeedW-1:0];
  endfunction

endpackage

// ===== sv/msl_seed_ram.sv =====
// Seed memory: one 31-bit entry per stream, valid bits select the power-on seed.
module msl_seed_ram
  import msl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ram_req_t         req_i,
  output logic [SeedW-1:0] rd_data_o
);

  logic [SeedW-1:0] seed_mem [StreamCount];
  logic             valid_q  [StreamCount];
  logic [SeedW-1:0] rd_data_q;
  logic             rd_valid_q;
  logic [AddrW-1:0] rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      seed_mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= seed_mem[req_i.rd_addr];
      rd_addr_q <= req_i.rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StreamCount; i++) begin
        valid_q[i] <= 1'b0;
      end
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  // Fall back to the power-on seed for an entry never written.
  assign rd_data_o = rd_valid_q ? rd_data_q : default_seed(StreamW'(rd_addr_q));

endmodule

// ===== sv/msl_mulmod.sv =====
// Shared constant multiplier with modulo 2^31-1 fold on the registered product.
module msl_mulmod
  import msl_pkg::*;
(
  input  logic             clk_i,
  input  mul_ctrl_t        ctrl_i,
  input  logic [SeedW-1:0] operand_i,
  output logic [SeedW-1:0] result_o
);

  logic [MultW-1:0] mult;
  logic [ProdW-1:0] prod_d;
  logic [ProdW-1:0] prod_q;

  always_comb begin
    mult   = ctrl_i.second ? SecondMult : FirstMult;
    prod_d = ProdW'(operand_i) * ProdW'(mult);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign result_o = fold_mod(prod_q);

endmodule

// ===== sv/multi_stream_lcg_generator.sv =====
// Top level of the multi-stream prime-modulus LCG: sequencer, output register.
//
//   channel | direction | fields                          | handshake
//   --------+-----------+---------------------------------+--------------------------
//   in      | input     | action_i, stream_i, seed_value_i | in_valid_i / in_stall_o
//   out     | output    | seed_out_o, uniform_fraction_o   | out_valid_o / out_stall_i
//
// A draw runs from acceptance through a seed memory read,
// then two passes through the shared multiplier, each followed by a modulo fold.
// A read needs only the memory read; a set or a dropped request completes in idle.
// Reset is asynchronous; per-entry valid bits return the power-on seed of any
// stream not yet written, so the seed memory needs no clearing pass.
// A stalled output holds its result; the input stays stalled while a new one waits.
module multi_stream_lcg_generator
  import msl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [StreamW-1:0] stream_i,
  input  logic [SeedW-1:0]   seed_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SeedW-1:0]   seed_out_o,
  output logic [FracW-1:0]   uniform_fraction_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_RED1,
    S_MUL2,
    S_RED2
  } state_e;

  state_e           state_q;
  logic             draw_q;
  logic [AddrW-1:0] addr_q;
  logic [SeedW-1:0] z_q;
  logic             out_valid_q;
  logic [SeedW-1:0] seed_out_q;
  logic [FracW-1:0] frac_q;

  ram_req_t         ram_req;
  mul_ctrl_t        mul_ctrl;
  logic [SeedW-1:0] mul_operand;
  logic [SeedW-1:0] mul_result;
  logic [SeedW-1:0] rd_data;
  logic             in_acc;
  logic             stream_ok;
  logic             out_free;
  logic             out_load;
  action_e          action;

  msl_seed_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  msl_mulmod u_mul (
    .clk_i     (clk_i),
    .ctrl_i    (mul_ctrl),
    .operand_i (mul_operand),
    .result_o  (mul_result)
  );

  // One transaction in flight at a time, so memory read and write-back of the
  // same entry never overlap and need no forwarding.
  always_comb begin
    action    = action_e'(action_i);
    in_acc    = in_valid_i && (state_q == S_IDLE);
    stream_ok = 32'(stream_i) < StreamCount;
    out_free  = !out_valid_q || !out_stall_i;
    // Load a result: read data on a read, the second fold on a draw.
    out_load  = out_free && (((state_q == S_FETCH) && !draw_q) || (state_q == S_RED2));

    ram_req         = '0;
    ram_req.rd_addr = stream_i[AddrW-1:0];
    ram_req.wr_addr = stream_i[AddrW-1:0];
    ram_req.wr_data = seed_value_i;
    mul_ctrl        = '0;
    mul_operand     = z_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && stream_ok) begin
          unique case (action)
            ACT_DRAW, ACT_READ: ram_req.rd_en = 1'b1;
            ACT_SET:            ram_req.wr_en = 1'b1;
            default:            ;
          endcase
        end
      end
      S_FETCH: begin
        // First multiply straight off the memory read data.
        if (draw_q) begin
          mul_ctrl.en = 1'b1;
          mul_operand = rd_data;
        end
      end
      S_MUL2: begin
        mul_ctrl.en     = 1'b1;
        mul_ctrl.second = 1'b1;
      end
      S_RED2: begin
        // Write back together with the result, only once the output is free.
        if (out_free) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = addr_q;
          ram_req.wr_data = mul_result;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // Hold a stalled result, drop it once taken, unless a new one loads.
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && stream_ok) begin
            addr_q <= stream_i[AddrW-1:0];
            if (action == ACT_DRAW) begin
              draw_q  <= 1'b1;
              state_q <= S_FETCH;
            end else if (action == ACT_READ) begin
              draw_q  <= 1'b0;
              state_q <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          if (draw_q) begin
            state_q <= S_RED1;
          end else if (out_free) begin
            seed_out_q  <= rd_data;
            frac_q      <= '0;
            state_q     <= S_IDLE;
          end
        end
        S_RED1: begin
          z_q     <= mul_result;
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          state_q <= S_RED2;
        end
        S_RED2: begin
          if (out_free) begin
            seed_out_q  <= mul_result;
            frac_q      <= mul_result[SeedW-1:SeedW-FracW] | FracW'(1);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o         = (state_q != S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign seed_out_o         = seed_out_q;
  assign uniform_fraction_o = frac_q;

endmodule

// ===== sv/msl_checker.sv =====
// Port-level checker for the multi-stream LCG, bound to the top level.
module msl_checker
  import msl_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         action_i,
  input logic [StreamW-1:0] stream_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [SeedW-1:0]   seed_out_o,
  input logic [FracW-1:0]   uniform_fraction_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(seed_out_o)
      && $stable(uniform_fraction_o))
    else $error("stalled output transaction changed");

  // A draw result carries the fraction taken from its own seed.
  a_frac_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (uniform_fraction_o != '0) |->
      uniform_fraction_o == (seed_out_o[SeedW-1:SeedW-FracW] | FracW'(1)))
    else $error("fraction does not match seed");

  // A draw seed is fully reduced below the modulus.
  a_draw_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (uniform_fraction_o != '0) |-> seed_out_o != PrimeMod[SeedW-1:0])
    else $error("draw seed not reduced");

  // An accepted draw on a valid stream keeps the input busy next cycle.
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ACT_DRAW)
      && (32'(stream_i) < StreamCount) |=> in_stall_o)
    else $error("input not stalled during draw");

endmodule

bind multi_stream_lcg_generator msl_checker u_msl_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .action_i           (action_i),
  .stream_i           (stream_i),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .seed_out_o         (seed_out_o),
  .uniform_fraction_o (uniform_fraction_o)
);
